@@ rtl/multi_pattern_byte_matcher_assert.svh @@
// assertion macros for the multi-pattern byte matcher checker
`ifndef MULTI_PATTERN_BYTE_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_BYTE_MATCHER_ASSERT_SVH
// same-cycle implication
`define MPBM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matcher port check failed");
// next-cycle implication
`define MPBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matcher port check failed");
`endif

@@ rtl/mpbm_pkg.sv @@
// types and codes shared by the matcher modules
package mpbm_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LINKS  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef struct packed {
    op_t        command;
    logic [7:0] symbol;
    logic       last;
    logic       mark_rule;
    logic [9:0] node_index;
    logic [9:0] suffix_target;
    logic [9:0] dict_target;
  } mpbm_in_t;

  typedef struct packed {
    logic [10:0] found_count;
    logic        all_found;
    logic        table_full;
    logic [10:0] nodes_used;
  } mpbm_out_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LINK,
    ST_HCLR,
    ST_INS_RD,
    ST_INS_EV,
    ST_RULE_RD,
    ST_RULE_EV,
    ST_V_RD,
    ST_V_EV,
    ST_V_CHK,
    ST_G_RD,
    ST_G_EV,
    ST_FIN
  } mpbm_state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic link;
    logic hclr;
    logic ins_ev;
    logic rule_rd;
    logic rule_ev;
    logic v_ev;
    logic v_chk;
    logic g_ev;
    logic fin;
  } ctrl_t;

  typedef struct packed {
    logic done;
    logic last;
    logic sweep_all_end;
    logic sweep_node_end;
    logic chain_more;
    logic eq;
    logic final_visit;
    logic term;
    logic out_free;
  } status_t;

endpackage

@@ rtl/mpbm_ram.sv @@
// generic simple dual-port ram with registered read
module mpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mpbm_ctrl.sv @@
// sequencer for insert, link write, clear and search
module mpbm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  mpbm_pkg::op_t     in_cmd,
  output logic              in_stall,
  input  mpbm_pkg::status_t status,
  output mpbm_pkg::ctrl_t   ctrl
);
  import mpbm_pkg::*;

  mpbm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:    if (status.sweep_all_end) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            OP_INSERT: state_nxt = ST_INS_RD;
            OP_LINKS:  state_nxt = ST_LINK;
            OP_CLEAR:  state_nxt = ST_HCLR;
            OP_SEARCH: state_nxt = status.done ? ST_FIN : ST_V_RD;
            default:   state_nxt = ST_FIN;
          endcase
        end
      end
      ST_LINK:    state_nxt = ST_FIN;
      ST_HCLR:    if (status.sweep_node_end) state_nxt = ST_FIN;
      ST_INS_RD:  state_nxt = ST_INS_EV;
      ST_INS_EV:  state_nxt = status.last ? ST_RULE_RD : ST_FIN;
      ST_RULE_RD: state_nxt = ST_RULE_EV;
      ST_RULE_EV: state_nxt = ST_FIN;
      ST_V_RD:    state_nxt = ST_V_EV;
      ST_V_EV:    state_nxt = status.chain_more ? ST_V_RD : ST_V_CHK;
      ST_V_CHK:   state_nxt = (status.final_visit || status.eq) ? ST_FIN : ST_G_RD;
      ST_G_RD:    state_nxt = ST_G_EV;
      ST_G_EV: begin
        if (status.term) begin
          state_nxt = status.last ? ST_V_RD : ST_FIN;
        end else begin
          state_nxt = ST_V_RD;
        end
      end
      ST_FIN:     if (status.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != ST_IDLE);
    ctrl         = '0;
    ctrl.load    = (state_r == ST_IDLE) && in_valid;
    ctrl.init    = (state_r == ST_INIT);
    ctrl.link    = (state_r == ST_LINK);
    ctrl.hclr    = (state_r == ST_HCLR);
    ctrl.ins_ev  = (state_r == ST_INS_EV);
    ctrl.rule_rd = (state_r == ST_RULE_RD);
    ctrl.rule_ev = (state_r == ST_RULE_EV);
    ctrl.v_ev    = (state_r == ST_V_EV);
    ctrl.v_chk   = (state_r == ST_V_CHK);
    ctrl.g_ev    = (state_r == ST_G_EV);
    ctrl.fin     = (state_r == ST_FIN) && status.out_free;
  end

endmodule

@@ rtl/mpbm_datapath.sv @@
// trie tables, counters, search cursor and result register
module mpbm_datapath #(
  parameter int NODE_CAPACITY = 1024,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mpbm_pkg::mpbm_in_t  in_data,
  input  mpbm_pkg::ctrl_t     ctrl,
  output mpbm_pkg::status_t   status,
  input  logic                out_stall,
  output logic                out_valid,
  output mpbm_pkg::mpbm_out_t out_data
);
  import mpbm_pkg::*;

  localparam int NW     = $clog2(NODE_CAPACITY);
  localparam int CW     = NW + 1;
  localparam int GDEPTH = NODE_CAPACITY * ALPHABET_SIZE;
  localparam int AW     = $clog2(GDEPTH);

  // item fields
  op_t           op_r;
  logic [7:0]    sym_r;
  logic          last_r, mark_r, idx_ok_r;
  logic [NW-1:0] idx_r, sfx_r, dct_r;

  // architectural state
  logic [NW-1:0] ins_cur_r, srch_r;
  logic [CW-1:0] node_tot_r, pat_tot_r, found_r;
  logic          done_r, full_r;

  // walk state
  logic [NW-1:0] m_r, fail_r;
  logic [CW-1:0] csteps_r, fsteps_r;
  logic          first_r, final_r;
  logic [AW-1:0] sweep_r;

  logic      out_valid_r, out_valid_nxt;
  mpbm_out_t out_data_r;

  // symbol reduction
  logic [16:0] sym_rem;
  logic [7:0]  sym_mod;

  always_comb begin
    sym_rem = 17'(in_data.symbol);
    for (int k = 7; k >= 0; k--) begin
      if (sym_rem >= (17'(ALPHABET_SIZE) << k)) begin
        sym_rem = sym_rem - (17'(ALPHABET_SIZE) << k);
      end
    end
    sym_mod = sym_rem[7:0];
  end

  logic          idx_ok;
  logic [NW-1:0] sfx_clip, dct_clip;

  assign idx_ok   = ({22'd0, in_data.node_index} < 32'(NODE_CAPACITY));
  assign sfx_clip = ({22'd0, in_data.suffix_target} < 32'(NODE_CAPACITY)) ?
                    NW'(in_data.suffix_target) : '0;
  assign dct_clip = ({22'd0, in_data.dict_target} < 32'(NODE_CAPACITY)) ?
                    NW'(in_data.dict_target) : '0;

  // memories
  logic            g_we, lk_we, rl_we, ht_we;
  logic [AW-1:0]   slot, g_waddr;
  logic [NW-1:0]   g_node, g_wdata, g_q;
  logic [NW-1:0]   lk_waddr, rl_waddr, ht_waddr, n_raddr;
  logic [2*NW-1:0] lk_wdata, lk_q;
  logic            rl_wdata, ht_wdata, rl_q, ht_q;

  assign g_node  = (op_r == OP_INSERT) ? ins_cur_r : srch_r;
  assign slot    = AW'(g_node) * AW'(ALPHABET_SIZE) + AW'(sym_r);
  assign n_raddr = ctrl.rule_rd ? ins_cur_r : m_r;

  mpbm_ram #(.WIDTH(NW), .DEPTH(GDEPTH)) u_goto (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(slot), .rdata(g_q)
  );
  mpbm_ram #(.WIDTH(2*NW), .DEPTH(NODE_CAPACITY)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata), .raddr(n_raddr),
    .rdata(lk_q)
  );
  mpbm_ram #(.WIDTH(1), .DEPTH(NODE_CAPACITY)) u_rule (
    .clk(clk), .we(rl_we), .waddr(rl_waddr), .wdata(rl_wdata), .raddr(n_raddr),
    .rdata(rl_q)
  );
  mpbm_ram #(.WIDTH(1), .DEPTH(NODE_CAPACITY)) u_hit (
    .clk(clk), .we(ht_we), .waddr(ht_waddr), .wdata(ht_wdata), .raddr(n_raddr),
    .rdata(ht_q)
  );

  logic [NW-1:0] fail_q, out_q;
  logic          child_nz, can_alloc, at_root, fmax, hit_new, chain_more, mark_ok, eq;

  assign fail_q     = lk_q[2*NW-1:NW];
  assign out_q      = lk_q[NW-1:0];
  assign child_nz   = (g_q != '0);
  assign can_alloc  = (node_tot_r < CW'(NODE_CAPACITY));
  assign at_root    = (srch_r == '0);
  assign fmax       = (fsteps_r >= CW'(NODE_CAPACITY));
  assign hit_new    = rl_q && !ht_q;
  assign chain_more = (out_q != '0) && (csteps_r < CW'(NODE_CAPACITY));
  assign mark_ok    = mark_r && (ins_cur_r != '0) && !rl_q;
  assign eq         = (found_r == pat_tot_r);

  always_comb begin
    g_we     = 1'b0;
    g_waddr  = slot;
    g_wdata  = NW'(node_tot_r);
    lk_we    = 1'b0;
    lk_waddr = NW'(node_tot_r);
    lk_wdata = '0;
    rl_we    = 1'b0;
    rl_waddr = ins_cur_r;
    rl_wdata = 1'b1;
    ht_we    = 1'b0;
    ht_waddr = m_r;
    ht_wdata = 1'b1;
    if (ctrl.init) begin
      g_we     = 1'b1;
      g_waddr  = sweep_r;
      g_wdata  = '0;
      lk_we    = 1'b1;
      lk_waddr = sweep_r[NW-1:0];
      rl_we    = 1'b1;
      rl_waddr = sweep_r[NW-1:0];
      rl_wdata = 1'b0;
    end
    if (ctrl.ins_ev && !child_nz && can_alloc) begin
      g_we  = 1'b1;
      lk_we = 1'b1;
    end
    if (ctrl.link && idx_ok_r) begin
      lk_we    = 1'b1;
      lk_waddr = idx_r;
      lk_wdata = {sfx_r, dct_r};
    end
    if (ctrl.rule_ev && mark_ok) begin
      rl_we = 1'b1;
    end
    if (ctrl.init || ctrl.hclr) begin
      ht_we    = 1'b1;
      ht_waddr = sweep_r[NW-1:0];
      ht_wdata = 1'b0;
    end else if (ctrl.v_ev && hit_new) begin
      ht_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      ins_cur_r   <= '0;
      srch_r      <= '0;
      node_tot_r  <= CW'(1);
      pat_tot_r   <= '0;
      found_r     <= '0;
      done_r      <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctrl.init || ctrl.hclr) sweep_r <= sweep_r + 1'b1;
      if (ctrl.load) begin
        sweep_r <= '0;
        full_r  <= 1'b0;
      end
      if (ctrl.hclr) begin
        found_r <= '0;
        done_r  <= 1'b0;
        srch_r  <= '0;
      end
      if (ctrl.ins_ev) begin
        if (child_nz) begin
          ins_cur_r <= g_q;
        end else if (can_alloc) begin
          ins_cur_r  <= NW'(node_tot_r);
          node_tot_r <= node_tot_r + 1'b1;
        end else begin
          full_r <= 1'b1;
        end
      end
      if (ctrl.rule_ev) begin
        if (mark_ok) begin
          pat_tot_r <= pat_tot_r + 1'b1;
          done_r    <= 1'b0;
        end
        ins_cur_r <= '0;
      end
      if (ctrl.v_ev && hit_new) found_r <= found_r + 1'b1;
      if (ctrl.v_chk) begin
        if (eq) done_r <= 1'b1;
        if (final_r) srch_r <= '0;
      end
      if (ctrl.g_ev) begin
        if (child_nz) begin
          srch_r <= g_q;
        end else if (!at_root) begin
          srch_r <= fmax ? '0 : fail_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r     <= in_data.command;
      sym_r    <= sym_mod;
      last_r   <= in_data.last;
      mark_r   <= in_data.mark_rule;
      idx_ok_r <= idx_ok;
      idx_r    <= NW'(in_data.node_index);
      sfx_r    <= sfx_clip;
      dct_r    <= dct_clip;
      m_r      <= srch_r;
      first_r  <= 1'b1;
      final_r  <= 1'b0;
      csteps_r <= '0;
      fsteps_r <= '0;
    end
    if (ctrl.v_ev) begin
      if (first_r) fail_r <= fail_q;
      if (chain_more) begin
        m_r      <= out_q;
        csteps_r <= csteps_r + 1'b1;
        first_r  <= 1'b0;
      end
    end
    if (ctrl.g_ev) begin
      first_r  <= 1'b1;
      csteps_r <= '0;
      if (child_nz) begin
        m_r     <= g_q;
        final_r <= 1'b1;
      end else if (at_root || fmax) begin
        m_r     <= '0;
        final_r <= 1'b1;
      end else begin
        m_r      <= fail_r;
        fsteps_r <= fsteps_r + 1'b1;
      end
    end
    if (ctrl.fin) begin
      out_data_r.found_count <= 11'(found_r);
      out_data_r.all_found   <= done_r;
      out_data_r.table_full  <= full_r;
      out_data_r.nodes_used  <= 11'(node_tot_r);
    end
  end

  assign out_valid_nxt = ctrl.fin ? 1'b1 : (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_comb begin
    status                = '0;
    status.done           = done_r;
    status.last           = last_r;
    status.sweep_all_end  = (sweep_r == AW'(GDEPTH - 1));
    status.sweep_node_end = (sweep_r == AW'(NODE_CAPACITY - 1));
    status.chain_more     = chain_more;
    status.eq             = eq;
    status.final_visit    = final_r;
    status.term           = child_nz || at_root || fmax;
    status.out_free       = !out_valid_r || !out_stall;
  end

endmodule

@@ rtl/multi_pattern_byte_matcher.sv @@
// top level of the multi-pattern byte matcher
// Aho-Corasick style matcher over a byte trie held in on-chip ram. Each input
// word carries one command: insert a pattern byte, write one node's failure and
// output links (computed by software), clear the search, or search one text
// byte. Every word returns exactly one result word with the found count, the
// all-found flag, the table-full flag and the node count. After reset the block
// sweeps all tables to zero and stalls input until done. Steps per word, from
// the accept to the result load: link write; insert, with an extra rule-flag
// read on the last byte of a pattern; clear, with a hit-flag sweep; search, a
// walk of the current node's output chain plus failure or goto steps, and a
// second chain walk and a check on a frame's last byte; a search byte while all
// patterns are found goes straight to the result. Every table walk goes through
// the single registered read port of the node rams. A result waits in the output
// register while the next word is taken.
module multi_pattern_byte_matcher #(
  parameter int NODE_CAPACITY = 1024,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mpbm_pkg::mpbm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mpbm_pkg::mpbm_out_t out_data
);
  import mpbm_pkg::*;

  // command strobes and status between sequencer and datapath
  ctrl_t   ctrl;
  status_t status;

  mpbm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_cmd  (in_data.command),
    .in_stall(in_stall),
    .status  (status),
    .ctrl    (ctrl)
  );

  // tables, cursors, counters and the result register
  mpbm_datapath #(
    .NODE_CAPACITY(NODE_CAPACITY),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ctrl     (ctrl),
    .status   (status),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

@@ rtl/mpbm_checker.sv @@
// port-level checker for the matcher and its bind
`include "multi_pattern_byte_matcher_assert.svh"

module mpbm_port_checker #(
  parameter int NODE_CAPACITY = 1024
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input mpbm_pkg::mpbm_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input mpbm_pkg::mpbm_out_t out_data
);
  import mpbm_pkg::*;

  localparam bit NARROW = (NODE_CAPACITY < 2048);

  logic [10:0] prev_nodes_r;
  logic        seen_r;
  logic        in_seen;
  logic        nodes_chk;
  logic        full_chk;

  assign in_seen   = in_valid && !in_stall && (in_data.command == OP_SEARCH);
  assign nodes_chk = NARROW && seen_r && out_valid && !in_seen;
  assign full_chk  = NARROW && out_valid && out_data.table_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      prev_nodes_r <= '0;
    end else if (out_valid && !out_stall) begin
      seen_r       <= 1'b1;
      prev_nodes_r <= out_data.nodes_used;
    end
  end

  // a stalled result word holds
  `MPBM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // node count never shrinks from one result word to the next
  `MPBM_ASSERT_SAME(a_nodes_mono, nodes_chk, out_data.nodes_used >= prev_nodes_r)
  // the table-full flag only shows with the node count at capacity
  `MPBM_ASSERT_SAME(a_full_cap, full_chk, out_data.nodes_used == 11'(NODE_CAPACITY))

endmodule

bind multi_pattern_byte_matcher mpbm_port_checker #(
  .NODE_CAPACITY(NODE_CAPACITY)
) u_mpbm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
